[hdl/lcs_pkg.sv]
// ----------------------------------------------------------------------------
// lcs_pkg
// shared types, constants and the sine table for the lane centre steering block
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int RHO_BINS      = 50;
    localparam int RHO_STEP_LOG  = 2;
    localparam int THETA_BINS    = 180;
    localparam int FRACTION_BITS = 10;
    localparam int IMAGE_ROWS    = 120;
    localparam int TABLE_SIZE    = 180;
    localparam int QUARTER_TURN  = 90;

    localparam int RHO_W    = 6;
    localparam int THETA_W  = 8;
    localparam int GAIN_W   = 12;
    localparam int STEER_W  = 10;
    localparam int TRIG_W   = 11;
    localparam int NUM_W    = 20;   // signed numerator
    localparam int DIV_BITS = 19;   // magnitude of numerator and quotient
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN  = 2'd1;

    localparam logic [GAIN_W-1:0] OFFSET_GAIN_RESET = 12'd51;
    localparam logic [GAIN_W-1:0] ANGLE_GAIN_RESET  = 12'd307;

    typedef struct packed {
        logic [RHO_W-1:0]   left_rho_index;
        logic [THETA_W-1:0] left_theta_index;
        logic [RHO_W-1:0]   right_rho_index;
        logic [THETA_W-1:0] right_theta_index;
    } in_t;

    typedef struct packed {
        logic [STEER_W-1:0] steering;
        logic               division_error;
    } out_t;

    // q10 sine of 0..179 degrees
    localparam logic [TRIG_W-1:0] SINE_Q [TABLE_SIZE] = '{
        'h0, 'h11, 'h23, 'h35, 'h47, 'h59, 'h6b, 'h7c, 'h8e, 'ha0, 'hb1, 'hc3, 'hd4, 'he6,
        'hf7, 'h109, 'h11a, 'h12b, 'h13c, 'h14d, 'h15e, 'h16e, 'h17f, 'h190, 'h1a0, 'h1b0,
        'h1c0, 'h1d0, 'h1e0, 'h1f0, 'h200, 'h20f, 'h21e, 'h22d, 'h23c, 'h24b, 'h259, 'h268,
        'h276, 'h284, 'h292, 'h29f, 'h2ad, 'h2ba, 'h2c7, 'h2d4, 'h2e0, 'h2ec, 'h2f8, 'h304,
        'h310, 'h31b, 'h326, 'h331, 'h33c, 'h346, 'h350, 'h35a, 'h364, 'h36d, 'h376, 'h37f,
        'h388, 'h390, 'h398, 'h3a0, 'h3a7, 'h3ae, 'h3b5, 'h3bb, 'h3c2, 'h3c8, 'h3cd, 'h3d3,
        'h3d8, 'h3dd, 'h3e1, 'h3e5, 'h3e9, 'h3ed, 'h3f0, 'h3f3, 'h3f6, 'h3f8, 'h3fa, 'h3fc,
        'h3fd, 'h3fe, 'h3ff, 'h3ff, 'h400, 'h3ff, 'h3ff, 'h3fe, 'h3fd, 'h3fc, 'h3fa, 'h3f8,
        'h3f6, 'h3f3, 'h3f0, 'h3ed, 'h3e9, 'h3e5, 'h3e1, 'h3dd, 'h3d8, 'h3d3, 'h3cd, 'h3c8,
        'h3c2, 'h3bb, 'h3b5, 'h3ae, 'h3a7, 'h3a0, 'h398, 'h390, 'h388, 'h37f, 'h376, 'h36d,
        'h364, 'h35a, 'h350, 'h346, 'h33c, 'h331, 'h326, 'h31b, 'h310, 'h304, 'h2f8, 'h2ec,
        'h2e0, 'h2d4, 'h2c7, 'h2ba, 'h2ad, 'h29f, 'h292, 'h284, 'h276, 'h268, 'h259, 'h24b,
        'h23c, 'h22d, 'h21e, 'h20f, 'h200, 'h1f0, 'h1e0, 'h1d0, 'h1c0, 'h1b0, 'h1a0, 'h190,
        'h17f, 'h16e, 'h15e, 'h14d, 'h13c, 'h12b, 'h11a, 'h109, 'hf7, 'he6, 'hd4, 'hc3,
        'hb1, 'ha0, 'h8e, 'h7c, 'h6b, 'h59, 'h47, 'h35, 'h23, 'h11};

    // sine lookup, zero outside the table
    function automatic logic [TRIG_W-1:0] sine_at(input logic [8:0] t);
        logic [TRIG_W-1:0] s;
        s = '0;
        if (t < 9'(TABLE_SIZE))
        begin
            s = SINE_Q[t[7:0]];
        end
        return s;
    endfunction

    // cosine magnitude; sign is negative from a quarter turn upwards
    function automatic logic [TRIG_W-1:0] cos_mag(input logic [THETA_W-1:0] t);
        logic [TRIG_W-1:0] c;
        if (t < THETA_W'(QUARTER_TURN))
        begin
            c = sine_at({1'b0, t} + 9'(QUARTER_TURN));
        end
        else
        begin
            c = sine_at({1'b0, t} - 9'(QUARTER_TURN));
        end
        return c;
    endfunction

endpackage

[hdl/lane_center_steering.sv]
// ----------------------------------------------------------------------------
// lane_center_steering
// steering correction from a pair of hough lane lines
// ----------------------------------------------------------------------------
// Takes one word per clock (busy is always low) and returns one result word
// per input word; done is high for exactly one cycle with the result. Nothing
// can stall the output. Each word passes through a lookup stage, the two
// 19-stage restoring dividers (one quotient bit per stage) that form the x
// intercepts, a centre stage, a gain-multiply stage and the output register.
// A theta at a quarter turn (zero cosine) or beyond the table gives steering 0
// and division_error 1. Gains are written through cfg_we/cfg_index/cfg_data
// and must only change while no word is in flight.
module lane_center_steering
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lcs_pkg::in_t                   in_word,
    input  logic                           cfg_we,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcs_pkg::GAIN_W-1:0]     cfg_data,
    output logic                           done,
    output lcs_pkg::out_t                  result
);

    localparam int NB      = lcs_pkg::DIV_BITS;
    localparam int TW      = lcs_pkg::TRIG_W;
    localparam int LATENCY = NB + 4;

    // configuration registers
    logic [lcs_pkg::GAIN_W-1:0] offset_gain_reg;
    logic [lcs_pkg::GAIN_W-1:0] angle_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_gain_reg <= lcs_pkg::OFFSET_GAIN_RESET;
            angle_gain_reg  <= lcs_pkg::ANGLE_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcs_pkg::CFG_OFFSET_GAIN: offset_gain_reg <= cfg_data;
                lcs_pkg::CFG_ANGLE_GAIN:  angle_gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- lookup stage: numerator, cosine, error ----------------
    logic [lcs_pkg::RHO_W-1:0]   rho_in   [2];
    logic [lcs_pkg::THETA_W-1:0] theta_in [2];
    logic [NB-1:0]               mag_next [2];
    logic [TW-1:0]               den_next [2];
    logic                        neg_next [2];
    logic                        bad_next [2];

    assign rho_in[0]   = in_word.left_rho_index;
    assign rho_in[1]   = in_word.right_rho_index;
    assign theta_in[0] = in_word.left_theta_index;
    assign theta_in[1] = in_word.right_theta_index;

    for (genvar l = 0; l < 2; l++)
    begin : g_lookup
        logic signed [lcs_pkg::NUM_W-1:0] num;
        logic [15:0]                      sin_term;
        logic [TW-1:0]                    cmag;
        always_comb
        begin
            sin_term = 16'(lcs_pkg::sine_at({1'b0, theta_in[l]}))
                       * 16'(lcs_pkg::IMAGE_ROWS / 2);
            num = ($signed({{(lcs_pkg::NUM_W-lcs_pkg::RHO_W){1'b0}}, rho_in[l]})
                   - lcs_pkg::NUM_W'(lcs_pkg::RHO_BINS / 2))
                  <<< (lcs_pkg::RHO_STEP_LOG + lcs_pkg::FRACTION_BITS);
            num = num + $signed({{(lcs_pkg::NUM_W-16){1'b0}}, sin_term});
            cmag = lcs_pkg::cos_mag(theta_in[l]);
            mag_next[l] = num[lcs_pkg::NUM_W-1] ? NB'(-num) : NB'(num);
            den_next[l] = cmag;
            neg_next[l] = num[lcs_pkg::NUM_W-1]
                          ^ (theta_in[l] >= lcs_pkg::THETA_W'(lcs_pkg::QUARTER_TURN));
            bad_next[l] = (theta_in[l] >= lcs_pkg::THETA_W'(lcs_pkg::THETA_BINS))
                          || (cmag == '0);
        end
    end

    logic [8:0] tsum;
    assign tsum = {1'b0, in_word.left_theta_index} + {1'b0, in_word.right_theta_index};

    // ---------------- divider pipeline, stage 0 is the lookup register ------
    logic          v_reg    [NB+1];
    logic          err_reg  [NB+1];
    logic [7:0]    thalf_reg[NB+1];
    logic [TW-1:0] rem_reg  [2][NB+1];
    logic [NB-1:0] dvd_reg  [2][NB+1];
    logic [NB-1:0] quo_reg  [2][NB+1];
    logic [TW-1:0] den_reg  [2][NB+1];
    logic          neg_reg  [2][NB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg[0]   <= bad_next[0] | bad_next[1];
        thalf_reg[0] <= tsum[8:1];
        for (int l = 0; l < 2; l++)
        begin
            rem_reg[l][0] <= '0;
            dvd_reg[l][0] <= mag_next[l];
            quo_reg[l][0] <= '0;
            den_reg[l][0] <= den_next[l];
            neg_reg[l][0] <= neg_next[l];
        end
    end

    for (genvar s = 0; s < NB; s++)
    begin : g_div
        logic [TW-1:0] rem_next [2];
        logic          qbit     [2];

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [TW:0] trial;
            always_comb
            begin
                trial = {rem_reg[l][s], dvd_reg[l][s][NB-1]};
                qbit[l] = trial >= {1'b0, den_reg[l][s]};
                rem_next[l] = qbit[l] ? TW'(trial - {1'b0, den_reg[l][s]}) : TW'(trial);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            err_reg[s+1]   <= err_reg[s];
            thalf_reg[s+1] <= thalf_reg[s];
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[l][s+1] <= rem_next[l];
                dvd_reg[l][s+1] <= {dvd_reg[l][s][NB-2:0], 1'b0};
                quo_reg[l][s+1] <= {quo_reg[l][s][NB-2:0], qbit[l]};
                den_reg[l][s+1] <= den_reg[l][s];
                neg_reg[l][s+1] <= neg_reg[l][s];
            end
        end
    end

    // ---------------- centre stage: signed intercepts, floor half-sum -------
    logic signed [NB:0]   lx, rx;
    logic signed [NB+1:0] xsum;
    logic signed [NB:0]   center_next;
    logic signed [8:0]    aerr_next;

    always_comb
    begin
        lx = neg_reg[0][NB] ? -$signed({1'b0, quo_reg[0][NB]}) : $signed({1'b0, quo_reg[0][NB]});
        rx = neg_reg[1][NB] ? -$signed({1'b0, quo_reg[1][NB]}) : $signed({1'b0, quo_reg[1][NB]});
        xsum = (NB+2)'(lx) + (NB+2)'(rx);
        center_next = (NB+1)'(xsum >>> 1);
        aerr_next = $signed({1'b0, thalf_reg[NB]}) - 9'sd90;
    end

    logic                 v_c_reg, err_c_reg;
    logic signed [NB:0]   center_reg;
    logic signed [8:0]    aerr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_c_reg <= 1'b0;
        end
        else
        begin
            v_c_reg <= v_reg[NB];
        end
    end

    always_ff @(posedge clk)
    begin
        err_c_reg  <= err_reg[NB];
        center_reg <= center_next;
        aerr_reg   <= aerr_next;
    end

    // ---------------- gain stage: one multiply per term ---------------------
    localparam int P1_W = NB + 1 + lcs_pkg::GAIN_W + 1;
    localparam int P2_W = 9 + lcs_pkg::GAIN_W + 1;

    logic                   v_p_reg, err_p_reg;
    logic signed [P1_W-1:0] p1_reg;
    logic signed [P2_W-1:0] p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_p_reg <= 1'b0;
        end
        else
        begin
            v_p_reg <= v_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        err_p_reg <= err_c_reg;
        p1_reg    <= P1_W'(center_reg) * P1_W'($signed({1'b0, offset_gain_reg}));
        p2_reg    <= P2_W'(aerr_reg) * P2_W'($signed({1'b0, angle_gain_reg}));
    end

    // ---------------- output stage ------------------------------------------
    logic signed [P1_W:0] steer_sum;
    lcs_pkg::out_t        result_next;

    always_comb
    begin
        steer_sum = -(P1_W+1)'(p1_reg) + (P1_W+1)'(p2_reg);
        result_next.division_error = err_p_reg;
        result_next.steering = err_p_reg ? '0
            : steer_sum[lcs_pkg::FRACTION_BITS +: lcs_pkg::STEER_W];
    end

    logic          done_reg;
    lcs_pkg::out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- assertions --------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.division_error |-> result.steering == '0)
        else $error("error word with nonzero steering");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted word not delivered on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result word without matching input");

endmodule
